// ===== hdl/cvt_pkg.sv =====
// ----------------------------------------------------------------------------
// cvt_pkg
// Shared constants, command codes and types for the 2D camera view transform.
// ----------------------------------------------------------------------------
package cvt_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int SCREEN_BITS_DEF = 12;

	localparam int TRIG_BITS  = 30;
	localparam int COORD_W    = 32;
	localparam int ANGLE_W    = 16;
	localparam int VH_W       = 31;
	localparam int SCR_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COEF_W     = 34;
	localparam int CAP_BIT    = 34;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_H   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 3'd5;

	localparam logic [VH_W-1:0]  VIEW_H_RST   = 31'd39321600;
	localparam logic [SCR_W-1:0] SCREEN_W_RST = 13'd1280;
	localparam logic [SCR_W-1:0] SCREEN_H_RST = 13'd720;

	// multiplier operand selects
	localparam logic [3:0] MS_NONE  = 4'd0;
	localparam logic [3:0] MS_XX    = 4'd1;
	localparam logic [3:0] MS_PX2   = 4'd2;
	localparam logic [3:0] MS_PX    = 4'd3;
	localparam logic [3:0] MS_A00DX = 4'd4;
	localparam logic [3:0] MS_A01DY = 4'd5;
	localparam logic [3:0] MS_A10DX = 4'd6;
	localparam logic [3:0] MS_A11DY = 4'd7;
	localparam logic [3:0] MS_ULO   = 4'd8;
	localparam logic [3:0] MS_UHI   = 4'd9;
	localparam logic [3:0] MS_VLO   = 4'd10;
	localparam logic [3:0] MS_VHI   = 4'd11;

	// write-back actions
	localparam logic [3:0] WB_NONE = 4'd0;
	localparam logic [3:0] WB_X2   = 4'd1;
	localparam logic [3:0] WB_HORN = 4'd2;
	localparam logic [3:0] WB_TRIG = 4'd3;
	localparam logic [3:0] WB_CS   = 4'd4;
	localparam logic [3:0] WB_ACC  = 4'd5;
	localparam logic [3:0] WB_U    = 4'd6;
	localparam logic [3:0] WB_V    = 4'd7;
	localparam logic [3:0] WB_ABS  = 4'd8;
	localparam logic [3:0] WB_NXLO = 4'd9;
	localparam logic [3:0] WB_NXHI = 4'd10;
	localparam logic [3:0] WB_NYLO = 4'd11;
	localparam logic [3:0] WB_NYHI = 4'd12;
	localparam logic [3:0] WB_DIV  = 4'd13;
	localparam logic [3:0] WB_RND  = 4'd14;

	typedef struct packed {
		logic       accept;
		logic [3:0] mul_sel;
		logic [3:0] wb;
		logic [2:0] hk;
		logic       e;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

	// odd Taylor coefficients of sin over a quarter turn, Q30
	function automatic logic signed [COEF_W-1:0] sin_coef(input logic [2:0] k);
		logic signed [COEF_W-1:0] r;
		case (k)
			3'd0:    r = 34'sd1686629713;
			3'd1:    r = 34'sd693598668;
			3'd2:    r = 34'sd85569305;
			3'd3:    r = 34'sd5026995;
			3'd4:    r = 34'sd172272;
			3'd5:    r = 34'sd3864;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/cvt_if.sv =====
// ----------------------------------------------------------------------------
// cvt_in_if / cvt_out_if
// Valid/ready channels for points in and transformed points out.
// ----------------------------------------------------------------------------
interface cvt_in_if;
	import cvt_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	modport source(output valid, kind, coord_x, coord_y, input ready);
	modport sink(input valid, kind, coord_x, coord_y, output ready);
endinterface

interface cvt_out_if;
	import cvt_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] result_x;
	logic signed [COORD_W-1:0] result_y;
	logic                      saturated;
	modport source(output valid, result_x, result_y, saturated, input ready);
	modport sink(input valid, result_x, result_y, saturated, output ready);
endinterface

// ===== hdl/cvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cvt_ctrl
// Sequencer: matrix rebuild, transform products, division and output word.
// ----------------------------------------------------------------------------
module cvt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_hit,
	input  cvt_pkg::status_t status,
	output cvt_pkg::cmd_t    cmd
);
	import cvt_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_TX2  = 5'd1;
	localparam logic [4:0] ST_TX2W = 5'd2;
	localparam logic [4:0] ST_THM  = 5'd3;
	localparam logic [4:0] ST_THW  = 5'd4;
	localparam logic [4:0] ST_TPX  = 5'd5;
	localparam logic [4:0] ST_TPW  = 5'd6;
	localparam logic [4:0] ST_TCS  = 5'd7;
	localparam logic [4:0] ST_M0   = 5'd8;
	localparam logic [4:0] ST_M1   = 5'd9;
	localparam logic [4:0] ST_M2   = 5'd10;
	localparam logic [4:0] ST_M3   = 5'd11;
	localparam logic [4:0] ST_M4   = 5'd12;
	localparam logic [4:0] ST_ABS  = 5'd13;
	localparam logic [4:0] ST_P0   = 5'd14;
	localparam logic [4:0] ST_P1   = 5'd15;
	localparam logic [4:0] ST_P2   = 5'd16;
	localparam logic [4:0] ST_P3   = 5'd17;
	localparam logic [4:0] ST_P4   = 5'd18;
	localparam logic [4:0] ST_DIV  = 5'd19;
	localparam logic [4:0] ST_RND  = 5'd20;
	localparam logic [4:0] ST_OUT  = 5'd21;

	logic [4:0] state_q, state_d;
	logic [2:0] hk_q, hk_d;
	logic       e_q, e_d;
	logic       mvalid_q;
	logic       out_valid_q;
	logic       set_valid;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		hk_d         = hk_q;
		e_d          = e_q;
		set_valid    = 1'b0;
		cmd          = '0;
		cmd.hk       = hk_q;
		cmd.e        = e_q;
		cmd.accept   = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					e_d     = 1'b0;
					state_d = mvalid_q ? ST_M0 : ST_TX2;
				end
			end
			ST_TX2: begin
				cmd.mul_sel = MS_XX;
				state_d     = ST_TX2W;
			end
			ST_TX2W: begin
				cmd.wb  = WB_X2;
				hk_d    = 3'd4;
				state_d = ST_THM;
			end
			ST_THM: begin
				cmd.mul_sel = MS_PX2;
				state_d     = ST_THW;
			end
			ST_THW: begin
				cmd.wb = WB_HORN;
				if (hk_q == 3'd0) begin
					state_d = ST_TPX;
				end else begin
					hk_d    = hk_q - 3'd1;
					state_d = ST_THM;
				end
			end
			ST_TPX: begin
				cmd.mul_sel = MS_PX;
				state_d     = ST_TPW;
			end
			ST_TPW: begin
				cmd.wb = WB_TRIG;
				if (!e_q) begin
					e_d     = 1'b1;
					state_d = ST_TX2;
				end else begin
					state_d = ST_TCS;
				end
			end
			ST_TCS: begin
				cmd.wb    = WB_CS;
				set_valid = 1'b1;
				state_d   = ST_M0;
			end
			ST_M0: begin
				cmd.mul_sel = MS_A00DX;
				state_d     = ST_M1;
			end
			ST_M1: begin
				cmd.mul_sel = MS_A01DY;
				cmd.wb      = WB_ACC;
				state_d     = ST_M2;
			end
			ST_M2: begin
				cmd.mul_sel = MS_A10DX;
				cmd.wb      = WB_U;
				state_d     = ST_M3;
			end
			ST_M3: begin
				cmd.mul_sel = MS_A11DY;
				cmd.wb      = WB_ACC;
				state_d     = ST_M4;
			end
			ST_M4: begin
				cmd.wb  = WB_V;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				cmd.wb  = WB_ABS;
				state_d = ST_P0;
			end
			ST_P0: begin
				cmd.mul_sel = MS_ULO;
				state_d     = ST_P1;
			end
			ST_P1: begin
				cmd.mul_sel = MS_UHI;
				cmd.wb      = WB_NXLO;
				state_d     = ST_P2;
			end
			ST_P2: begin
				cmd.mul_sel = MS_VLO;
				cmd.wb      = WB_NXHI;
				state_d     = ST_P3;
			end
			ST_P3: begin
				cmd.mul_sel = MS_VHI;
				cmd.wb      = WB_NYLO;
				state_d     = ST_P4;
			end
			ST_P4: begin
				cmd.wb  = WB_NYHI;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.wb = WB_DIV;
				if (status.div_last) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				cmd.wb  = WB_RND;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hk_q        <= 3'd0;
			e_q         <= 1'b0;
			mvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hk_q    <= hk_d;
			e_q     <= e_d;
			if (cfg_hit) begin
				mvalid_q <= 1'b0;
			end else if (set_valid) begin
				mvalid_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/cvt_dpath.sv =====
// ----------------------------------------------------------------------------
// cvt_dpath
// Registers, shared multiplier, trig evaluation and two restoring dividers.
// ----------------------------------------------------------------------------
module cvt_dpath #(
	parameter int FRAC_BITS   = cvt_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS  = cvt_pkg::ANGLE_BITS_DEF,
	parameter int SCREEN_BITS = cvt_pkg::SCREEN_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_hit,
	input  logic [cvt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cvt_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  in_kind,
	input  logic signed [cvt_pkg::COORD_W-1:0]    in_x,
	input  logic signed [cvt_pkg::COORD_W-1:0]    in_y,
	input  cvt_pkg::cmd_t                         cmd,
	output cvt_pkg::status_t                      status,
	output logic signed [cvt_pkg::COORD_W-1:0]    res_x,
	output logic signed [cvt_pkg::COORD_W-1:0]    res_y,
	output logic                                  res_sat
);
	import cvt_pkg::*;

	localparam int OFS_W   = SCREEN_BITS + FRAC_BITS;
	localparam int DX_W    = ((OFS_W + 1 > 32) ? OFS_W + 1 : 32) + 1;
	localparam int MUL_W   = ((DX_W > 33) ? DX_W : 33) + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int UW      = DX_W + 31;
	localparam int SW      = UW + 1;
	localparam int NW      = UW + 32;
	localparam int CNT_W   = $clog2(NW);
	localparam int MAG_W   = CAP_BIT + 1;
	localparam int R_W     = ((OFS_W + 1 > MAG_W + 1) ? OFS_W + 1 : MAG_W + 1) + 1;
	localparam int SH_W2S  = TRIG_BITS - FRAC_BITS;
	localparam int SH_S2W  = TRIG_BITS + FRAC_BITS;
	localparam int DIM_W   = SCREEN_BITS + 1;
	localparam int QA_W    = ANGLE_BITS - 2;

	localparam logic [NW:0] HALF_W2S = (NW + 1)'(1) << (SH_W2S - 1);
	localparam logic [NW:0] HALF_S2W = (NW + 1)'(1) << (SH_S2W - 1);
	localparam logic [NW:0] CAP      = (NW + 1)'(1) << CAP_BIT;
	localparam logic signed [R_W-1:0] MAX32 = R_W'($signed(33'h0_7FFF_FFFF));
	localparam logic signed [R_W-1:0] MIN32 = R_W'($signed(32'h8000_0000));
	localparam logic [TRIG_BITS:0] T_ONE = (TRIG_BITS + 1)'(1) << TRIG_BITS;

	// configuration
	logic signed [COORD_W-1:0] cam_x_q, cam_y_q;
	logic [ANGLE_W-1:0]        angle_q;
	logic [VH_W-1:0]           vh_q;
	logic [SCR_W-1:0]          sw_q, sh_q;

	// cached rotation
	logic signed [31:0]        c_q, s_q;
	logic [TRIG_BITS:0]        sq_q, cq_q, x2_q;
	logic signed [COEF_W-1:0]  p_q;

	// item
	logic                      kind_q;
	logic signed [DX_W-1:0]    dx_q, dy_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SW-1:0]      acc_q, u_q, v_q;
	logic                      negx_q, negy_q;
	logic [NW-1:0]             numx_q, numy_q;
	logic [31:0]               remx_q, remy_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [MAG_W-1:0]          magx_q, magy_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q;
	logic                      res_sat_q;

	logic [DIM_W-1:0]          w_cl, h_cl;
	logic [VH_W-1:0]           vh_cl;
	logic [31:0]               mul_b, div_d;
	logic [OFS_W-1:0]          ofs_w, ofs_h, in_ofs_w, in_ofs_h;
	logic [TRIG_BITS:0]        x_base, xe;
	logic signed [31:0]        a01, a10;
	logic signed [MUL_W-1:0]   opa, opb;
	logic signed [PROD_W-1:0]  tr;
	logic [32:0]               tx, ty;
	logic                      gex, gey;
	logic signed [R_W-1:0]     ofsx, ofsy, mx, my, rx, ry;
	logic [1:0]                quad;

	function automatic logic [DIM_W-1:0] screen_dim(input logic [SCR_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > (32'd1 << SCREEN_BITS)) begin
			r = DIM_W'(1) << SCREEN_BITS;
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] round_cap(input logic [NW-1:0] q, input logic k);
		logic [NW:0] t;
		t = k ? (({1'b0, q} + HALF_W2S) >> SH_W2S) : (({1'b0, q} + HALF_S2W) >> SH_S2W);
		if (t > CAP) begin
			t = CAP;
		end
		return t[MAG_W-1:0];
	endfunction

	assign w_cl  = screen_dim(sw_q);
	assign h_cl  = screen_dim(sh_q);
	assign vh_cl = (vh_q == '0) ? VH_W'(1) : vh_q;
	assign ofs_w = {w_cl, {(FRAC_BITS - 1){1'b0}}};
	assign ofs_h = {h_cl, {(FRAC_BITS - 1){1'b0}}};
	assign in_ofs_w = ofs_w;
	assign in_ofs_h = ofs_h;

	// world to screen scales by height / view height, the inverse by the reverse
	assign mul_b = kind_q ? 32'(h_cl) : 32'(vh_cl);
	assign div_d = kind_q ? 32'(vh_cl) : 32'(h_cl);

	assign x_base = (TRIG_BITS + 1)'(angle_q[QA_W-1:0]) << (TRIG_BITS - QA_W);
	assign xe     = cmd.e ? (T_ONE - x_base) : x_base;
	assign quad   = angle_q[ANGLE_BITS-1 -: 2];

	assign a01 = kind_q ? s_q : -s_q;
	assign a10 = kind_q ? -s_q : s_q;

	always_comb begin
		case (cmd.mul_sel)
			MS_XX: begin
				opa = MUL_W'($signed({1'b0, xe}));
				opb = MUL_W'($signed({1'b0, xe}));
			end
			MS_PX2: begin
				opa = MUL_W'(p_q);
				opb = MUL_W'($signed({1'b0, x2_q}));
			end
			MS_PX: begin
				opa = MUL_W'(p_q);
				opb = MUL_W'($signed({1'b0, xe}));
			end
			MS_A00DX: begin
				opa = MUL_W'(c_q);
				opb = MUL_W'(dx_q);
			end
			MS_A01DY: begin
				opa = MUL_W'(a01);
				opb = MUL_W'(dy_q);
			end
			MS_A10DX: begin
				opa = MUL_W'(a10);
				opb = MUL_W'(dx_q);
			end
			MS_A11DY: begin
				opa = MUL_W'(c_q);
				opb = MUL_W'(dy_q);
			end
			MS_ULO: begin
				opa = MUL_W'($signed({1'b0, u_q[31:0]}));
				opb = MUL_W'($signed({1'b0, mul_b}));
			end
			MS_UHI: begin
				opa = MUL_W'($signed({1'b0, u_q[UW-1:32]}));
				opb = MUL_W'($signed({1'b0, mul_b}));
			end
			MS_VLO: begin
				opa = MUL_W'($signed({1'b0, v_q[31:0]}));
				opb = MUL_W'($signed({1'b0, mul_b}));
			end
			MS_VHI: begin
				opa = MUL_W'($signed({1'b0, v_q[UW-1:32]}));
				opb = MUL_W'($signed({1'b0, mul_b}));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign tr = prod_q >>> TRIG_BITS;

	// one quotient bit per lane each cycle
	assign tx  = {remx_q, numx_q[NW-1]};
	assign ty  = {remy_q, numy_q[NW-1]};
	assign gex = (tx >= {1'b0, div_d});
	assign gey = (ty >= {1'b0, div_d});

	assign ofsx = kind_q ? R_W'($signed({1'b0, ofs_w})) : R_W'(cam_x_q);
	assign ofsy = kind_q ? R_W'($signed({1'b0, ofs_h})) : R_W'(cam_y_q);
	assign mx   = R_W'($signed({1'b0, magx_q}));
	assign my   = R_W'($signed({1'b0, magy_q}));
	assign rx   = ofsx + (negx_q ? -mx : mx);
	assign ry   = ofsy + (negy_q ? -my : my);

	assign status.div_last = (cnt_q == CNT_W'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			angle_q <= '0;
			vh_q    <= VIEW_H_RST;
			sw_q    <= SCREEN_W_RST;
			sh_q    <= SCREEN_H_RST;
		end else if (cfg_hit) begin
			case (cfg_index)
				CFG_CAM_X:    cam_x_q <= $signed(cfg_wdata[COORD_W-1:0]);
				CFG_CAM_Y:    cam_y_q <= $signed(cfg_wdata[COORD_W-1:0]);
				CFG_ANGLE:    angle_q <= cfg_wdata[ANGLE_W-1:0];
				CFG_VIEW_H:   vh_q    <= cfg_wdata[VH_W-1:0];
				CFG_SCREEN_W: sw_q    <= cfg_wdata[SCR_W-1:0];
				CFG_SCREEN_H: sh_q    <= cfg_wdata[SCR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		if (cmd.accept) begin
			kind_q <= in_kind;
			if (in_kind) begin
				dx_q <= DX_W'(in_x) - DX_W'(cam_x_q);
				dy_q <= DX_W'(in_y) - DX_W'(cam_y_q);
			end else begin
				dx_q <= DX_W'(in_x) - DX_W'($signed({1'b0, in_ofs_w}));
				dy_q <= DX_W'(in_y) - DX_W'($signed({1'b0, in_ofs_h}));
			end
		end
		if (cmd.load_out) begin
			res_sat_q <= (rx > MAX32) || (rx < MIN32) || (ry > MAX32) || (ry < MIN32);
			if (rx > MAX32) begin
				res_x_q <= 32'sh7FFF_FFFF;
			end else if (rx < MIN32) begin
				res_x_q <= 32'sh8000_0000;
			end else begin
				res_x_q <= rx[COORD_W-1:0];
			end
			if (ry > MAX32) begin
				res_y_q <= 32'sh7FFF_FFFF;
			end else if (ry < MIN32) begin
				res_y_q <= 32'sh8000_0000;
			end else begin
				res_y_q <= ry[COORD_W-1:0];
			end
		end
		case (cmd.wb)
			WB_X2: begin
				x2_q <= tr[TRIG_BITS:0];
				p_q  <= sin_coef(3'd5);
			end
			WB_HORN: begin
				p_q <= sin_coef(cmd.hk) - tr[COEF_W-1:0];
			end
			WB_TRIG: begin
				// clamp to [0, one]
				if (tr < 0) begin
					if (cmd.e) cq_q <= '0;
					else       sq_q <= '0;
				end else if (tr > PROD_W'(T_ONE)) begin
					if (cmd.e) cq_q <= T_ONE;
					else       sq_q <= T_ONE;
				end else begin
					if (cmd.e) cq_q <= tr[TRIG_BITS:0];
					else       sq_q <= tr[TRIG_BITS:0];
				end
			end
			WB_CS: begin
				case (quad)
					2'd0: begin
						s_q <= $signed({1'b0, sq_q});
						c_q <= $signed({1'b0, cq_q});
					end
					2'd1: begin
						s_q <= $signed({1'b0, cq_q});
						c_q <= -$signed({1'b0, sq_q});
					end
					2'd2: begin
						s_q <= -$signed({1'b0, sq_q});
						c_q <= -$signed({1'b0, cq_q});
					end
					default: begin
						s_q <= -$signed({1'b0, cq_q});
						c_q <= $signed({1'b0, sq_q});
					end
				endcase
			end
			WB_ACC: begin
				acc_q <= prod_q[SW-1:0];
			end
			WB_U: begin
				u_q <= acc_q + $signed(prod_q[SW-1:0]);
			end
			WB_V: begin
				v_q <= acc_q + $signed(prod_q[SW-1:0]);
			end
			WB_ABS: begin
				negx_q <= u_q[SW-1];
				negy_q <= v_q[SW-1];
				u_q    <= u_q[SW-1] ? -u_q : u_q;
				v_q    <= v_q[SW-1] ? -v_q : v_q;
			end
			WB_NXLO: begin
				numx_q <= NW'(prod_q[63:0]);
			end
			WB_NXHI: begin
				numx_q <= numx_q + {prod_q[UW-1:0], 32'b0};
			end
			WB_NYLO: begin
				numy_q <= NW'(prod_q[63:0]);
			end
			WB_NYHI: begin
				numy_q <= numy_q + {prod_q[UW-1:0], 32'b0};
				remx_q <= '0;
				remy_q <= '0;
				cnt_q  <= '0;
			end
			WB_DIV: begin
				remx_q <= gex ? 32'(tx - {1'b0, div_d}) : tx[31:0];
				remy_q <= gey ? 32'(ty - {1'b0, div_d}) : ty[31:0];
				numx_q <= {numx_q[NW-2:0], gex};
				numy_q <= {numy_q[NW-2:0], gey};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			WB_RND: begin
				magx_q <= round_cap(numx_q, kind_q);
				magy_q <= round_cap(numy_q, kind_q);
			end
			default: begin
			end
		endcase
	end

	assign res_x   = res_x_q;
	assign res_y   = res_y_q;
	assign res_sat = res_sat_q;

endmodule

// ===== hdl/camera_view_transform_2d_core.sv =====
// ----------------------------------------------------------------------------
// camera_view_transform_2d_core
// 2D camera transform between screen pixels and world units, Q16.16.
// ----------------------------------------------------------------------------
// channel  dir  handshake      word
// req      in   valid/ready    kind, coord_x, coord_y
// rsp      out  valid/ready    result_x, result_y, saturated
// cfg      in   cfg_we only    cfg_index, cfg_wdata
//
// The time from acceptance to a result is set by the two bit-per-cycle
// restoring dividers run side by side over NW bits (NW = 96 by default).
// The first item after a register write first rebuilds sin/cos on the shared
// multiplier. One item at a time; a new one is taken once the previous result
// sits in the output register, which holds while rsp stalls. Reset returns the
// configuration registers to their defaults and forces a rebuild.
// ----------------------------------------------------------------------------
module camera_view_transform_2d_core #(
	parameter int FRAC_BITS   = cvt_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS  = cvt_pkg::ANGLE_BITS_DEF,
	parameter int SCREEN_BITS = cvt_pkg::SCREEN_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cvt_in_if.sink                         req,
	cvt_out_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [cvt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cvt_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    cfg_hit;

	// writes beyond the register list are dropped
	assign cfg_hit = cfg_we && (cfg_index <= CFG_SCREEN_H);

	cvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cfg_hit   (cfg_hit),
		.status    (status),
		.cmd       (cmd)
	);

	cvt_dpath #(
		.FRAC_BITS   (FRAC_BITS),
		.ANGLE_BITS  (ANGLE_BITS),
		.SCREEN_BITS (SCREEN_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_hit   (cfg_hit),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_kind   (req.kind),
		.in_x      (req.coord_x),
		.in_y      (req.coord_y),
		.cmd       (cmd),
		.status    (status),
		.res_x     (rsp.result_x),
		.res_y     (rsp.result_y),
		.res_sat   (rsp.saturated)
	);

endmodule
